### design/urb_pkg.sv
// urb_pkg: shared types, register word map, ID byte table and helper
// functions for the uart register block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package urb_pkg;

  localparam int OFFSET_W = 12;
  localparam int WORD_W   = 10;
  localparam int DATA_W   = 32;

  // access kinds
  localparam logic ACT_READ  = 1'b0;
  localparam logic ACT_WRITE = 1'b1;

  // access sizes
  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_HALF = 2'd1;

  // word map (byte offset >> 2)
  localparam logic [WORD_W-1:0] WORD_DATA     = 10'd0;
  localparam logic [WORD_W-1:0] WORD_CTRL_AL  = 10'd1;
  localparam logic [WORD_W-1:0] WORD_FLAG     = 10'd6;
  localparam logic [WORD_W-1:0] WORD_IRDA     = 10'd8;
  localparam logic [WORD_W-1:0] WORD_BAUD_INT = 10'd9;
  localparam logic [WORD_W-1:0] WORD_BAUD_FRC = 10'd10;
  localparam logic [WORD_W-1:0] WORD_LCR      = 10'd11;
  localparam logic [WORD_W-1:0] WORD_CTRL     = 10'd12;
  localparam logic [WORD_W-1:0] WORD_FIFO_LVL = 10'd13;
  localparam logic [WORD_W-1:0] WORD_IRQ_MASK = 10'd14;
  localparam logic [WORD_W-1:0] WORD_IRQ_RAW  = 10'd15;
  localparam logic [WORD_W-1:0] WORD_IRQ_MIS  = 10'd16;
  localparam logic [WORD_W-1:0] WORD_IRQ_CLR  = 10'd17;
  localparam logic [WORD_W-1:0] WORD_DMA      = 10'd18;

  // id window starts at byte offset 0xfe0
  localparam logic [6:0] ID_WIN_TOP = 7'h7f;

  // interrupt and flag bits
  localparam int IRQ_W = 6;
  localparam logic [IRQ_W-1:0] INT_TX    = 6'h20;
  localparam logic [IRQ_W-1:0] INT_RX    = 6'h10;
  localparam logic [7:0]       FLAG_RXFF = 8'h40;
  localparam logic [7:0]       FLAG_RXFE = 8'h10;

  // reset values, and the dma control bits held at zero
  localparam logic [7:0]        FLAG_RST     = 8'h90;
  localparam logic [DATA_W-1:0] CTRL_RST     = 32'h0000_0300;
  localparam logic [DATA_W-1:0] FIFO_LVL_RST = 32'h0000_0012;
  localparam logic [DATA_W-1:0] DMA_FIXED0   = 32'h0000_0003;

  typedef struct packed {
    logic [DATA_W-1:0]   write_data;
    logic [1:0]          access_size;
    logic [OFFSET_W-1:0] byte_offset;
    logic                action;
  } req_t;

  typedef struct packed {
    logic              irq_pending;
    logic [7:0]        tx_byte;
    logic              tx_valid;
    logic              bus_error;
    logic [DATA_W-1:0] read_data;
  } rsp_t;

  function automatic logic [DATA_W-1:0] width_mask(input logic [1:0] size);
    logic [DATA_W-1:0] m;
    case (size)
      SIZE_BYTE: m = 32'h0000_00ff;
      SIZE_HALF: m = 32'h0000_ffff;
      default:   m = 32'hffff_ffff;
    endcase
    return m;
  endfunction

  function automatic logic [DATA_W-1:0] merge(input logic [DATA_W-1:0] old,
                                              input logic [DATA_W-1:0] keep,
                                              input logic [DATA_W-1:0] data);
    return (old & keep) | (data & ~keep);
  endfunction

  function automatic logic [7:0] id_byte(input logic variant, input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'h11;
      3'd1:    b = variant ? 8'h00 : 8'h10;
      3'd2:    b = variant ? 8'h18 : 8'h14;
      3'd3:    b = variant ? 8'h01 : 8'h00;
      3'd4:    b = 8'h0d;
      3'd5:    b = 8'hf0;
      3'd6:    b = 8'h05;
      default: b = 8'hb1;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

### design/uart_register_block_core.sv
// uart_register_block_core: top level of the uart register block.
// Depends on urb_pkg, urb_in_stage and urb_regfile.
//
// One bus access enters per in_ beat: in_tuser is the access kind (0 read,
// 1 write), in_tdata carries offset, size and write data. Each access gives
// exactly one out_ beat with read data, bus error, tx strobe and byte, and
// the masked interrupt status after the access.
// The access is registered in the input register when accepted, and its
// result is then registered in the result register, which holds the out_
// beat until it is taken.
// Throughput: one access per cycle while out_tready is high, set by the single
// decode and update stage between the input register and the result register.
// When out_tready is low the result register holds and the input register
// takes one more beat; in_tready then falls until the result drains.
// The cfg_ port writes the id variant bit at any edge with cfg_wr_en high outside reset.
// Reset (rst_n low, synchronous) empties both registers and returns all
// uart registers to their power-up values.
`timescale 1ns / 1ps
`default_nettype none

module uart_register_block_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_wr_data,   // id_variant
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,      // byte_offset, access_size, write_data, zero pad
  input  wire logic        in_tuser,      // action
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata      // read_data, bus_error, tx_valid, tx_byte,
                                          // irq_pending, zero pad
);

  urb_pkg::req_t in_req;
  urb_pkg::req_t s1_req;
  urb_pkg::rsp_t rsp;
  logic          s1_valid;
  logic          s1_ready;

  assign in_req.action      = in_tuser;
  assign in_req.byte_offset = in_tdata[11:0];
  assign in_req.access_size = in_tdata[13:12];
  assign in_req.write_data  = in_tdata[45:14];

  urb_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_req   (in_req),
    .s1_valid (s1_valid),
    .s1_ready (s1_ready),
    .s1_req   (s1_req)
  );

  urb_regfile u_regfile (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s1_valid    (s1_valid),
    .s1_ready    (s1_ready),
    .s1_req      (s1_req),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_rsp     (rsp)
  );

  assign out_tdata = {5'd0, rsp};

endmodule

`default_nettype wire

### design/urb_in_stage.sv
// urb_in_stage: input register of the uart register block; holds one
// accepted access beat until the register file takes it.
// Depends on urb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module urb_in_stage (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire urb_pkg::req_t in_req,
  output logic               s1_valid,
  input  wire logic          s1_ready,
  output urb_pkg::req_t      s1_req
);

  logic          valid_r;
  logic          valid_nxt;
  urb_pkg::req_t req_r;
  logic          load;

  assign in_ready  = !valid_r || s1_ready;
  assign load      = in_valid && in_ready;
  assign valid_nxt = load || (valid_r && !s1_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      req_r <= in_req;
    end
  end

  assign s1_valid = valid_r;
  assign s1_req   = req_r;

endmodule

`default_nettype wire

### design/urb_regfile.sv
// urb_regfile: decode, register state update and result register of the
// uart register block, plus the id variant setting.
// Depends on urb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module urb_regfile (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_wr_en,
  input  wire logic          cfg_wr_data,
  input  wire logic          s1_valid,
  output logic               s1_ready,
  input  wire urb_pkg::req_t s1_req,
  output logic               out_valid,
  input  wire logic          out_ready,
  output urb_pkg::rsp_t      out_rsp
);

  logic                            id_variant_r;
  logic [7:0]                      flag_r, flag_nxt;
  logic [urb_pkg::DATA_W-1:0]      lcr_r, lcr_nxt;
  logic [urb_pkg::DATA_W-1:0]      ctrl_r, ctrl_nxt;
  logic [urb_pkg::DATA_W-1:0]      dma_r, dma_nxt;
  logic [urb_pkg::DATA_W-1:0]      mask_r, mask_nxt;
  logic [urb_pkg::IRQ_W-1:0]       raw_r, raw_nxt;
  logic [urb_pkg::DATA_W-1:0]      irda_r, irda_nxt;
  logic [urb_pkg::DATA_W-1:0]      ibrd_r, ibrd_nxt;
  logic [urb_pkg::DATA_W-1:0]      fbrd_r, fbrd_nxt;
  logic [urb_pkg::DATA_W-1:0]      fifo_r, fifo_nxt;
  logic                            out_valid_r, out_valid_nxt;
  urb_pkg::rsp_t                   rsp_r, rsp_nxt;

  logic                            load;
  logic [urb_pkg::WORD_W-1:0]      word;
  logic [urb_pkg::DATA_W-1:0]      wmask;
  logic [urb_pkg::DATA_W-1:0]      keep;
  logic [urb_pkg::DATA_W-1:0]      data;
  logic [urb_pkg::DATA_W-1:0]      rd;
  logic                            err;

  assign s1_ready      = !out_valid_r || out_ready;
  assign load          = s1_valid && s1_ready;
  assign out_valid_nxt = load || (out_valid_r && !out_ready);

  assign word  = s1_req.byte_offset[urb_pkg::OFFSET_W-1:2];
  assign wmask = urb_pkg::width_mask(s1_req.access_size);
  assign keep  = ~wmask;
  assign data  = s1_req.write_data & wmask;

  always_comb begin
    flag_nxt = flag_r;
    lcr_nxt  = lcr_r;
    ctrl_nxt = ctrl_r;
    dma_nxt  = dma_r;
    mask_nxt = mask_r;
    raw_nxt  = raw_r;
    irda_nxt = irda_r;
    ibrd_nxt = ibrd_r;
    fbrd_nxt = fbrd_r;
    fifo_nxt = fifo_r;
    rd       = '0;
    err      = 1'b0;
    rsp_nxt  = '0;
    if (s1_req.action == urb_pkg::ACT_WRITE) begin
      case (word)
        urb_pkg::WORD_DATA: begin
          rsp_nxt.tx_valid = 1'b1;
          rsp_nxt.tx_byte  = data[7:0];
          raw_nxt          = raw_r | urb_pkg::INT_TX;
        end
        urb_pkg::WORD_CTRL_AL, urb_pkg::WORD_CTRL: begin
          ctrl_nxt = urb_pkg::merge(ctrl_r, keep, data);
        end
        urb_pkg::WORD_FLAG: begin
        end
        urb_pkg::WORD_IRDA:     irda_nxt = urb_pkg::merge(irda_r, keep, data);
        urb_pkg::WORD_BAUD_INT: ibrd_nxt = urb_pkg::merge(ibrd_r, keep, data);
        urb_pkg::WORD_BAUD_FRC: fbrd_nxt = urb_pkg::merge(fbrd_r, keep, data);
        urb_pkg::WORD_LCR:      lcr_nxt  = data;
        urb_pkg::WORD_FIFO_LVL: fifo_nxt = urb_pkg::merge(fifo_r, keep, data);
        urb_pkg::WORD_IRQ_MASK: mask_nxt = urb_pkg::merge(mask_r, keep, data);
        urb_pkg::WORD_IRQ_CLR:  raw_nxt  = raw_r & ~data[urb_pkg::IRQ_W-1:0];
        urb_pkg::WORD_DMA: begin
          dma_nxt = urb_pkg::merge(dma_r, keep, data) & ~urb_pkg::DMA_FIXED0;
        end
        default: err = 1'b1;
      endcase
    end else begin
      case (word)
        urb_pkg::WORD_DATA: begin
          flag_nxt = (flag_r & ~urb_pkg::FLAG_RXFF) | urb_pkg::FLAG_RXFE;
          raw_nxt  = raw_r & ~urb_pkg::INT_RX;
        end
        urb_pkg::WORD_CTRL_AL:  rd = '0;
        urb_pkg::WORD_FLAG:     rd = {24'd0, flag_r};
        urb_pkg::WORD_IRDA:     rd = irda_r;
        urb_pkg::WORD_BAUD_INT: rd = ibrd_r;
        urb_pkg::WORD_BAUD_FRC: rd = fbrd_r;
        urb_pkg::WORD_LCR:      rd = lcr_r;
        urb_pkg::WORD_CTRL:     rd = ctrl_r;
        urb_pkg::WORD_FIFO_LVL: rd = fifo_r;
        urb_pkg::WORD_IRQ_MASK: rd = mask_r;
        urb_pkg::WORD_IRQ_RAW:  rd = {26'd0, raw_r};
        urb_pkg::WORD_IRQ_MIS:  rd = {26'd0, raw_r & mask_r[urb_pkg::IRQ_W-1:0]};
        urb_pkg::WORD_DMA:      rd = dma_r;
        default: begin
          if (s1_req.byte_offset[urb_pkg::OFFSET_W-1:5] == urb_pkg::ID_WIN_TOP) begin
            rd = {24'd0, urb_pkg::id_byte(id_variant_r, s1_req.byte_offset[4:2])};
          end else begin
            err = 1'b1;
          end
        end
      endcase
    end
    rsp_nxt.read_data   = err ? '0 : (rd & wmask);
    rsp_nxt.bus_error   = err;
    rsp_nxt.irq_pending = |(raw_nxt & mask_nxt[urb_pkg::IRQ_W-1:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      id_variant_r <= 1'b0;
      flag_r       <= urb_pkg::FLAG_RST;
      lcr_r        <= '0;
      ctrl_r       <= urb_pkg::CTRL_RST;
      dma_r        <= '0;
      mask_r       <= '0;
      raw_r        <= '0;
      irda_r       <= '0;
      ibrd_r       <= '0;
      fbrd_r       <= '0;
      fifo_r       <= urb_pkg::FIFO_LVL_RST;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        id_variant_r <= cfg_wr_data;
      end
      if (load) begin
        flag_r <= flag_nxt;
        lcr_r  <= lcr_nxt;
        ctrl_r <= ctrl_nxt;
        dma_r  <= dma_nxt;
        mask_r <= mask_nxt;
        raw_r  <= raw_nxt;
        irda_r <= irda_nxt;
        ibrd_r <= ibrd_nxt;
        fbrd_r <= fbrd_nxt;
        fifo_r <= fifo_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp_r <= rsp_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = rsp_r;

  // only tx and rx raw bits can ever be set
  a_raw_bits: assert property (@(posedge clk) disable iff (!rst_n)
    raw_r[3:0] == 4'd0)
    else $error("undefined raw interrupt bit set");

  a_dma_low: assert property (@(posedge clk) disable iff (!rst_n)
    dma_r[1:0] == 2'd0)
    else $error("dma control low bits not held at zero");

  a_err_rd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && rsp_r.bus_error |-> rsp_r.read_data == '0 && !rsp_r.tx_valid)
    else $error("bus error beat carries data or tx strobe");

  a_rx_read: assert property (@(posedge clk) disable iff (!rst_n)
    load && s1_req.action == urb_pkg::ACT_READ && word == urb_pkg::WORD_DATA
    |=> !flag_r[6] && flag_r[4] && !raw_r[4])
    else $error("data register read did not update rx flags");

  a_tx_raise: assert property (@(posedge clk) disable iff (!rst_n)
    load && s1_req.action == urb_pkg::ACT_WRITE && word == urb_pkg::WORD_DATA
    |=> raw_r[5] && out_valid_r && rsp_r.tx_valid)
    else $error("data register write did not raise tx");

endmodule

`default_nettype wire
